/* hw/rtl/bdpc_pkg.sv */
// ----------------------------------------------------------------------------
// bdpc_pkg
// Shared constants and control types for the button debounce and press
// classifier.
// ----------------------------------------------------------------------------
package bdpc_pkg;

  // Counter widths and limits
  localparam int HELD_WIDTH   = 24;
  localparam int STABLE_WIDTH = 11;
  localparam int PULSE_WIDTH  = 16;
  localparam int TICK_WIDTH   = 16;
  localparam int DEB_WIDTH    = 10;
  localparam int PROG_WIDTH   = 7;
  localparam int CFG_IDX_W    = 3;
  localparam int CFG_DATA_W   = 16;

  // Percentage divider sizes: quotient stays below 128
  localparam int NUM_WIDTH    = TICK_WIDTH + PROG_WIDTH;
  localparam int DEN_WIDTH    = TICK_WIDTH + PROG_WIDTH - 1;
  localparam int DIV_STEPS    = PROG_WIDTH;

  localparam logic [PROG_WIDTH-1:0] PERCENT = 7'd100;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_ENABLE     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ACTIVE_LOW = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_DEBOUNCE   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SHORT      = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_LONG       = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_INTERVAL   = 3'd5;

  // Event codes
  localparam logic [1:0] EV_NONE  = 2'd0;
  localparam logic [1:0] EV_SHORT = 2'd1;
  localparam logic [1:0] EV_LONG  = 2'd2;

  // Controller to datapath commands
  typedef struct packed {
    logic step;     // apply one tick to the button state
    logic mul;      // load held*100 into the divider
    logic div;      // one restoring division step
    logic load;     // move the finished result to the output register
  } bdpc_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic out_free; // output register can take a result this cycle
  } bdpc_sts_t;

endpackage

/* hw/rtl/bdpc_in_if.sv */
// ----------------------------------------------------------------------------
// bdpc_in_if
// Tick channel: one raw pin sample per transfer.
// ----------------------------------------------------------------------------
interface bdpc_in_if;
  logic valid;
  logic ready;
  logic raw_level;

  modport source (output valid, output raw_level, input ready);
  modport sink (input valid, input raw_level, output ready);
endinterface

/* hw/rtl/bdpc_out_if.sv */
// ----------------------------------------------------------------------------
// bdpc_out_if
// Result channel: one classification result per transfer.
// ----------------------------------------------------------------------------
interface bdpc_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  event_res;
  logic        pressed;
  logic [23:0] held_time;
  logic [6:0]  progress;
  logic        waiting_long;
  logic        held_pulse;

  modport source (output valid, output event_res, output pressed, output held_time,
                  output progress, output waiting_long, output held_pulse, input ready);
  modport sink (input valid, input event_res, input pressed, input held_time,
                input progress, input waiting_long, input held_pulse, output ready);
endinterface

/* hw/rtl/button_debounce_press_classifier.sv */
// Sequence: tick, multiply, 7-step serial percentage divide and output load; no new tick is
// taken until the load is done, and out valid rises with the registered result.
// A result held on the output stalls the load and so the next tick.
// Reset (rst_n, synchronous): button state cleared, configuration registers to their defaults,
// output channel empty.
// ----------------------------------------------------------------------------
// button_debounce_press_classifier
// Debounces a sampled button and classifies short presses, long presses and
// periodic held pulses, with held time and long-press progress.
// ----------------------------------------------------------------------------
module button_debounce_press_classifier (
  input  logic                             clk,
  input  logic                             rst_n,
  bdpc_in_if.sink                          in_ch,
  bdpc_out_if.source                       out_ch,
  input  logic                             cfg_we,
  input  logic [bdpc_pkg::CFG_IDX_W-1:0]   cfg_idx,
  input  logic [bdpc_pkg::CFG_DATA_W-1:0]  cfg_wdata
);
  import bdpc_pkg::*;

  bdpc_cmd_t cmd;
  bdpc_sts_t sts;

  // Sequencer
  bdpc_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // Datapath
  bdpc_dp u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .sts              (sts),
    .raw_level        (in_ch.raw_level),
    .cfg_we           (cfg_we),
    .cfg_idx          (cfg_idx),
    .cfg_wdata        (cfg_wdata),
    .out_valid        (out_ch.valid),
    .out_ready        (out_ch.ready),
    .out_event_res    (out_ch.event_res),
    .out_pressed      (out_ch.pressed),
    .out_held_time    (out_ch.held_time),
    .out_progress     (out_ch.progress),
    .out_waiting_long (out_ch.waiting_long),
    .out_held_pulse   (out_ch.held_pulse)
  );

endmodule

/* hw/rtl/bdpc_ctrl.sv */
// ----------------------------------------------------------------------------
// bdpc_ctrl
// Sequencer: takes a tick, runs the multiply and the serial percentage
// divide, then hands the result to the output register.
// ----------------------------------------------------------------------------
module bdpc_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  bdpc_pkg::bdpc_sts_t sts,
  output bdpc_pkg::bdpc_cmd_t cmd
);
  import bdpc_pkg::*;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_MUL  = 2'd1;
  localparam logic [1:0] ST_DIV  = 2'd2;
  localparam logic [1:0] ST_LOAD = 2'd3;

  localparam logic [2:0] LAST_STEP = 3'(DIV_STEPS - 1);

  logic [1:0] state_r, state_nxt;
  logic [2:0] cnt_r, cnt_nxt;

  // Next state and commands
  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    cmd       = '0;
    in_ready  = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.step  = 1'b1;
          state_nxt = ST_MUL;
        end
      end
      ST_MUL: begin
        cmd.mul   = 1'b1;
        cnt_nxt   = '0;
        state_nxt = ST_DIV;
      end
      ST_DIV: begin
        cmd.div = 1'b1;
        cnt_nxt = cnt_r + 3'd1;
        if (cnt_r == LAST_STEP) begin
          state_nxt = ST_LOAD;
        end
      end
      ST_LOAD: begin
        if (sts.out_free) begin
          cmd.load  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

endmodule

/* hw/rtl/bdpc_dp.sv */
// ----------------------------------------------------------------------------
// bdpc_dp
// Datapath: configuration registers, debounce and press state, percentage
// divider and the output register.
// ----------------------------------------------------------------------------
module bdpc_dp (
  input  logic                                clk,
  input  logic                                rst_n,
  input  bdpc_pkg::bdpc_cmd_t                 cmd,
  output bdpc_pkg::bdpc_sts_t                 sts,
  input  logic                                raw_level,
  input  logic                                cfg_we,
  input  logic [bdpc_pkg::CFG_IDX_W-1:0]      cfg_idx,
  input  logic [bdpc_pkg::CFG_DATA_W-1:0]     cfg_wdata,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [1:0]                          out_event_res,
  output logic                                out_pressed,
  output logic [bdpc_pkg::HELD_WIDTH-1:0]     out_held_time,
  output logic [bdpc_pkg::PROG_WIDTH-1:0]     out_progress,
  output logic                                out_waiting_long,
  output logic                                out_held_pulse
);
  import bdpc_pkg::*;

  localparam logic [HELD_WIDTH-1:0]   HELD_MAX   = '1;
  localparam logic [STABLE_WIDTH-1:0] STABLE_MAX = '1;
  localparam logic [PULSE_WIDTH-1:0]  PULSE_MAX  = '1;

  // Configuration
  logic                  enable_r;
  logic                  active_low_r;
  logic [DEB_WIDTH-1:0]  debounce_r;
  logic [TICK_WIDTH-1:0] short_r;
  logic [TICK_WIDTH-1:0] long_r;
  logic [TICK_WIDTH-1:0] interval_r;

  // Button state
  logic                    last_r, last_nxt;
  logic [STABLE_WIDTH-1:0] stable_r, stable_nxt;
  logic                    pressed_r, pressed_nxt;
  logic [HELD_WIDTH-1:0]   held_r, held_nxt;
  logic                    fired_r, fired_nxt;
  logic [PULSE_WIDTH-1:0]  pcnt_r, pcnt_nxt;
  logic [1:0]              ev_r, ev_nxt;
  logic                    pulse_r, pulse_nxt;
  logic                    reading;

  // Divider
  logic [NUM_WIDTH-1:0]  rem_r;
  logic [DEN_WIDTH-1:0]  den_r;
  logic [PROG_WIDTH-1:0] quo_r;
  logic                  ge;

  // Output
  logic                  out_valid_r;
  logic [PROG_WIDTH-1:0] prog;
  logic                  wait_flag;
  logic                  held_ge_long;

  // Configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      enable_r     <= 1'b1;
      active_low_r <= 1'b1;
      debounce_r   <= 10'd50;
      short_r      <= 16'd1000;
      long_r       <= 16'd3000;
      interval_r   <= 16'd100;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        CFG_ENABLE:     enable_r     <= cfg_wdata[0];
        CFG_ACTIVE_LOW: active_low_r <= cfg_wdata[0];
        CFG_DEBOUNCE:   debounce_r   <= cfg_wdata[DEB_WIDTH-1:0];
        CFG_SHORT:      short_r      <= cfg_wdata;
        CFG_LONG:       long_r       <= cfg_wdata;
        CFG_INTERVAL:   interval_r   <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // One tick of debounce and press classification
  always_comb begin
    reading     = raw_level ^ active_low_r;
    last_nxt    = last_r;
    stable_nxt  = stable_r;
    pressed_nxt = pressed_r;
    held_nxt    = held_r;
    fired_nxt   = fired_r;
    pcnt_nxt    = pcnt_r;
    ev_nxt      = EV_NONE;
    pulse_nxt   = 1'b0;
    if (enable_r) begin
      // held and pulse counters run while pressed
      if (pressed_r) begin
        if (held_r != HELD_MAX) held_nxt = held_r + 1'b1;
        if (pcnt_r != PULSE_MAX) pcnt_nxt = pcnt_r + 1'b1;
      end
      // stability counter
      if (reading != last_r) begin
        stable_nxt = '0;
      end else if (stable_r != STABLE_MAX) begin
        stable_nxt = stable_r + 1'b1;
      end
      // debounced transitions and long press
      if (stable_nxt > {1'b0, debounce_r}) begin
        if (reading != pressed_r) begin
          pressed_nxt = reading;
          if (reading) begin
            held_nxt  = '0;
            fired_nxt = 1'b0;
            pcnt_nxt  = '0;
          end else begin
            if (!fired_r && (held_nxt < HELD_WIDTH'(long_r))) ev_nxt = EV_SHORT;
            held_nxt = '0;
          end
        end
        if (pressed_nxt && !fired_nxt && (held_nxt >= HELD_WIDTH'(long_r))) begin
          ev_nxt    = EV_LONG;
          fired_nxt = 1'b1;
        end
      end
      last_nxt = reading;
      // periodic held pulse
      if (pressed_nxt && (pcnt_nxt >= interval_r)) begin
        pulse_nxt = 1'b1;
        pcnt_nxt  = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_r    <= 1'b0;
      stable_r  <= '0;
      pressed_r <= 1'b0;
      held_r    <= '0;
      fired_r   <= 1'b0;
      pcnt_r    <= '0;
      ev_r      <= EV_NONE;
      pulse_r   <= 1'b0;
    end else if (cmd.step) begin
      last_r    <= last_nxt;
      stable_r  <= stable_nxt;
      pressed_r <= pressed_nxt;
      held_r    <= held_nxt;
      fired_r   <= fired_nxt;
      pcnt_r    <= pcnt_nxt;
      ev_r      <= ev_nxt;
      pulse_r   <= pulse_nxt;
    end
  end

  // Restoring divide of held*100 by long_ticks, one quotient bit per cycle.
  // Only used when held < long_ticks, so held fits 16 bits and quotient < 100.
  assign ge = rem_r >= {1'b0, den_r};

  always_ff @(posedge clk) begin
    if (cmd.mul) begin
      rem_r <= NUM_WIDTH'(held_r[TICK_WIDTH-1:0]) * NUM_WIDTH'(PERCENT);
      den_r <= {long_r, (PROG_WIDTH-1)'(0)};
      quo_r <= '0;
    end else if (cmd.div) begin
      if (ge) rem_r <= rem_r - {1'b0, den_r};
      den_r <= den_r >> 1;
      quo_r <= {quo_r[PROG_WIDTH-2:0], ge};
    end
  end

  // Result fields from the state after the tick
  assign held_ge_long = held_r >= HELD_WIDTH'(long_r);

  always_comb begin
    prog      = '0;
    wait_flag = 1'b0;
    if (pressed_r) begin
      if (held_ge_long || (long_r == '0)) prog = PERCENT;
      else                                prog = quo_r;
      wait_flag = (held_r >= HELD_WIDTH'(short_r)) && !held_ge_long && !fired_r;
    end
  end

  // Output register
  assign sts.out_free = !out_valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      out_event_res    <= ev_r;
      out_pressed      <= pressed_r;
      out_held_time    <= pressed_r ? held_r : '0;
      out_progress     <= prog;
      out_waiting_long <= wait_flag;
      out_held_pulse   <= pulse_r;
    end
  end

  assign out_valid = out_valid_r;

endmodule
